### design/dhcp_opt_pkg.sv
`default_nettype none
package dhcp_opt_pkg;

    // Largest data length whose bytes are all kept in the option value.
    localparam int MAX_VALUE_BYTES = 8;
    localparam int GATHER_W        = 8 * MAX_VALUE_BYTES;
    localparam int VALUE_W         = 64;

    localparam logic [7:0] END_CODE     = 8'hff;
    localparam logic [7:0] RESET_CODE   = 8'd93;
    localparam logic [3:0] RESET_LENGTH = 4'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_CODE   = 2'd0,
        CFG_TARGET_LENGTH = 2'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_CODE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_END       = 2'd1,
        ST_EXHAUSTED = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] code;
        logic [3:0] length;
    } t_cfg;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] value;
        t_status            status;
    } t_result;

endpackage
`default_nettype wire

### design/dhcp_opt_walker.sv
`default_nettype none
module dhcp_opt_walker
    import dhcp_opt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    input  wire t_cfg       i_cfg,
    output t_result         o_result,
    output logic            o_result_valid
);

    t_phase              r_phase,        n_phase;
    logic [7:0]          r_bytes_left,   n_bytes_left;
    logic                r_code_matches, n_code_matches;
    logic [GATHER_W-1:0] r_gather,       n_gather;

    logic                emit;
    t_status             emit_status;
    logic [GATHER_W-1:0] emit_value;
    logic                len_match;
    logic [7:0]          dec_left;
    logic [GATHER_W-1:0] shifted;

    assign len_match = r_code_matches && (i_data_byte == {4'b0, i_cfg.length});
    assign dec_left  = r_bytes_left - 8'd1;
    assign shifted   = {r_gather[GATHER_W-9:0], i_data_byte};

    always_comb begin
        n_phase        = r_phase;
        n_bytes_left   = r_bytes_left;
        n_code_matches = r_code_matches;
        n_gather       = r_gather;
        emit           = 1'b0;
        emit_status    = ST_EXHAUSTED;
        emit_value     = '0;

        unique case (r_phase)
            PH_CODE: begin
                if (i_data_byte == END_CODE) begin
                    emit        = 1'b1;
                    emit_status = ST_END;
                end else begin
                    n_code_matches = (i_data_byte == i_cfg.code);
                    n_phase        = PH_LEN;
                    emit           = i_last_byte;
                end
            end
            PH_LEN: begin
                n_code_matches = len_match;
                n_bytes_left   = i_data_byte;
                n_gather       = '0;
                if (len_match && i_data_byte == 8'd0) begin
                    emit        = 1'b1;
                    emit_status = ST_FOUND;
                end else begin
                    n_phase = (i_data_byte == 8'd0) ? PH_CODE : PH_DATA;
                    emit    = i_last_byte;
                end
            end
            PH_DATA: begin
                n_bytes_left = dec_left;
                if (r_code_matches) begin
                    n_gather = shifted;
                    if (dec_left == 8'd0) begin
                        emit        = 1'b1;
                        emit_status = ST_FOUND;
                        emit_value  = shifted;
                    end else begin
                        emit = i_last_byte;
                    end
                end else begin
                    if (dec_left == 8'd0) begin
                        n_phase = PH_CODE;
                    end
                    emit = i_last_byte;
                end
            end
            PH_DONE: begin
                if (i_last_byte) begin
                    n_phase = PH_CODE;
                end
            end
            default: begin
                n_phase = PH_CODE;
            end
        endcase

        // Any report ends the walk; the packet's last byte restarts it.
        if (emit) begin
            n_phase = i_last_byte ? PH_CODE : PH_DONE;
        end
    end

    always_comb begin
        o_result_valid  = i_step && emit;
        o_result.found  = (emit_status == ST_FOUND);
        o_result.value  = VALUE_W'(emit_value);
        o_result.status = emit_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_CODE;
            r_bytes_left   <= '0;
            r_code_matches <= 1'b0;
            r_gather       <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_bytes_left   <= n_bytes_left;
            r_code_matches <= n_code_matches;
            r_gather       <= n_gather;
        end
    end

endmodule
`default_nettype wire

### design/dhcp_opt_result_buf.sv
`default_nettype none
module dhcp_opt_result_buf
    import dhcp_opt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic         o_can_push,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_head_valid, r_skid_valid;
    t_result r_head, r_skid;
    logic    head_free;

    assign head_free  = !r_head_valid || i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_head_valid;
    assign o_result   = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (head_free) begin
            // advance: skid moves up first, a new result fills behind it
            r_head_valid <= r_skid_valid || i_push;
            r_skid_valid <= r_skid_valid && i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_free) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
                r_skid <= i_result;
            end else begin
                r_head <= i_result;
            end
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

endmodule
`default_nettype wire

### design/dhcp_option_extractor_core.sv
// DHCP option extractor.
// Input channel (i_in_valid / o_in_ready): one byte of the options section per
// transfer, with i_last_byte on the packet's final byte. The bytes are walked
// as code, length, data records; the walk stops at code 0xff.
// Output channel (o_out_valid / i_out_ready): at most one result per packet
// walk: found with the option data assembled big-endian, end marker seen, or
// buffer ran out. After a report the rest of the packet is dropped.
// Configuration channel (i_cfg_valid / o_cfg_ready): index 0 sets the option
// code searched for (reset 93), index 1 the data length it must have (reset 2).
// Write only while no byte is in flight.
// A result is registered in the result buffer before it reaches the output.
// Throughput: one byte per cycle while o_in_ready is high, set by the walker's
// per-byte state update. A two-entry result buffer sits on the output; when
// it is full o_in_ready drops until the receiver takes a result, so a stalled
// receiver holds the input without losing anything.
// Reset: walker restarts at an option code, buffer empties, registers return
// to their defaults.
`default_nettype none
module dhcp_option_extractor_core
    import dhcp_opt_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_last_byte,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_found,
    output logic [VALUE_W-1:0]          o_option_value,
    output logic [1:0]                  o_status,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg    r_cfg;
    logic    step;
    logic    step_result_valid;
    t_result step_result;
    t_result out_result;

    assign o_cfg_ready = 1'b1;
    assign step        = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code   <= RESET_CODE;
            r_cfg.length <= RESET_LENGTH;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TARGET_CODE:   r_cfg.code   <= i_cfg_data;
                CFG_TARGET_LENGTH: r_cfg.length <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    dhcp_opt_walker u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_cfg          (r_cfg),
        .o_result       (step_result),
        .o_result_valid (step_result_valid)
    );

    dhcp_opt_result_buf u_result_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (step_result_valid),
        .i_result   (step_result),
        .o_can_push (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_found        = out_result.found;
    assign o_option_value = out_result.value;
    assign o_status       = out_result.status;

`ifndef SYNTHESIS
    a_stall_means_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_found == (o_status == ST_FOUND)))
        else $error("found flag disagrees with status");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_option_value == '0))
        else $error("option value nonzero without a match");

    a_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
